// File: sv/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants for the ring deque: store geometry, field widths, codes.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int DEPTH      = 256;
  localparam int ELEM_WIDTH = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 9;
  localparam int POS_W      = 9;
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;
  localparam int VALUE_W    = 64;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STAT_W + VALUE_W + CNT_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

endpackage

// File: sv/rdq_ram.sv
// ----------------------------------------------------------------------------
// rdq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/ring_deque_indexed_insert_remove.sv
// ----------------------------------------------------------------------------
// ring_deque_indexed_insert_remove
// Deque in a ring RAM with head pointer and count; indexed insert/remove/read, and clear.
// ----------------------------------------------------------------------------
// An insert or remove moves the words on the shorter side of the position (at
// most 128), one word per cycle; a read, a clear or a rejected request moves no
// word. Only one request is in flight: the next input transfer is taken the cycle
// after the result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the deque, zeroes the head; RAM kept.
// ----------------------------------------------------------------------------
module ring_deque_indexed_insert_remove (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: position[8:0], value[72:9], zero pad above
  input  logic [rdq_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: action[1:0]
  input  logic [rdq_pkg::ACT_W-1:0]     in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: status[1:0], read_value[65:2], count_after[74:66], zero pad above
  output logic [rdq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready
);

  localparam int AW = rdq_pkg::ADDR_W;
  localparam int CW = rdq_pkg::CNT_W;
  localparam int PW = rdq_pkg::POS_W;
  localparam int VW = rdq_pkg::VALUE_W;
  localparam int SW = rdq_pkg::STAT_W;
  localparam int OUT_PAD = rdq_pkg::OUT_DATA_W - SW - VW - CW;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [CW-1:0] DEPTH_CNT = CW'(rdq_pkg::DEPTH);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]                  state_r, state_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;

  // Latched request (payload, no reset needed)
  logic [rdq_pkg::ACT_W-1:0]   act_r, act_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [VW-1:0]               val_r, val_nxt;

  // Shift engine: cur_r is the next destination, the source is one step on
  logic [AW-1:0]               cur_r, cur_nxt;
  logic                        dir_up_r, dir_up_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;
  logic                        wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]               wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]               fin_addr_r, fin_addr_nxt;

  // Result under construction and output register
  logic [SW-1:0]               stat_r, stat_nxt;
  logic [VW-1:0]               rd_r, rd_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [SW-1:0]               out_stat_r, out_stat_nxt;
  logic [VW-1:0]               out_rd_r, out_rd_nxt;
  logic [CW-1:0]               out_cnt_r, out_cnt_nxt;

  // RAM ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [rdq_pkg::ELEM_WIDTH-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [rdq_pkg::ELEM_WIDTH-1:0] ram_rdata;

  // Decode helpers for the latched request
  logic [AW-1:0] pos_a, cnt_a, step_a, slot_pos;
  logic          front_side;

  assign pos_a      = pos_r[AW-1:0];
  assign cnt_a      = cnt_r[AW-1:0];
  assign slot_pos   = head_r + pos_a;
  assign front_side = pos_r < (cnt_r >> 1);
  assign step_a     = dir_up_r ? (cur_r + AW'(1)) : (cur_r - AW'(1));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_cnt_r, out_rd_r, out_stat_r};

  rdq_ram #(
    .WIDTH (rdq_pkg::ELEM_WIDTH),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    dir_up_nxt    = dir_up_r;
    rem_nxt       = rem_r;
    wr_pend_nxt   = wr_pend_r;
    wr_addr_nxt   = wr_addr_r;
    fin_addr_nxt  = fin_addr_r;
    stat_nxt      = stat_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;

    ram_we    = 1'b0;
    ram_waddr = wr_addr_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = step_a;

    // Drop the result once the downstream side takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser;
          pos_nxt   = in_tdata[PW-1:0];
          val_nxt   = in_tdata[PW+VW-1:PW];
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        stat_nxt    = rdq_pkg::STAT_OK;
        rd_nxt      = '0;
        wr_pend_nxt = 1'b0;
        state_nxt   = S_DONE;
        unique case (act_r)
          rdq_pkg::ACT_INSERT: begin
            if (pos_r > cnt_r) begin
              stat_nxt = rdq_pkg::STAT_INVALID;
            end else if (cnt_r == DEPTH_CNT) begin
              stat_nxt = rdq_pkg::STAT_FULL;
            end else begin
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_SHIFT;
              if (front_side) begin
                // Move the front part one slot toward the new head
                cur_nxt      = head_r - AW'(1);
                dir_up_nxt   = 1'b1;
                rem_nxt      = CW'(pos_r);
                fin_addr_nxt = head_r - AW'(1) + pos_a;
                head_nxt     = head_r - AW'(1);
              end else begin
                // Move the back part one slot toward the tail
                cur_nxt      = head_r + cnt_a;
                dir_up_nxt   = 1'b0;
                rem_nxt      = cnt_r - CW'(pos_r);
                fin_addr_nxt = slot_pos;
              end
            end
          end
          rdq_pkg::ACT_REMOVE: begin
            if (pos_r >= cnt_r) begin
              stat_nxt = rdq_pkg::STAT_INVALID;
            end else begin
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_SHIFT;
              cur_nxt   = slot_pos;
              if (front_side) begin
                dir_up_nxt = 1'b0;
                rem_nxt    = CW'(pos_r);
                head_nxt   = head_r + AW'(1);
              end else begin
                dir_up_nxt = 1'b1;
                rem_nxt    = cnt_r - CW'(1) - CW'(pos_r);
              end
            end
          end
          rdq_pkg::ACT_READ: begin
            if (pos_r >= cnt_r) begin
              stat_nxt = rdq_pkg::STAT_INVALID;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot_pos;
              state_nxt = S_RDWAIT;
            end
          end
          rdq_pkg::ACT_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SHIFT: begin
        // Read the source one step ahead, write it to its destination next cycle
        if (rem_r != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = step_a;
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = cur_r;
          cur_nxt     = step_a;
          rem_nxt     = rem_r - CW'(1);
        end else begin
          wr_pend_nxt = 1'b0;
        end
        if (wr_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_r;
          ram_wdata = ram_rdata;
        end else if (rem_r == '0) begin
          // Shift finished: place the new word for an insert
          if (act_r == rdq_pkg::ACT_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = fin_addr_r;
            ram_wdata = val_r[rdq_pkg::ELEM_WIDTH-1:0];
          end
          state_nxt = S_DONE;
        end
      end

      S_RDWAIT: begin
        rd_nxt    = VW'(ram_rdata);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_rd_nxt    = rd_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    dir_up_r   <= dir_up_nxt;
    rem_r      <= rem_nxt;
    wr_addr_r  <= wr_addr_nxt;
    fin_addr_r <= fin_addr_nxt;
    stat_r     <= stat_nxt;
    rd_r       <= rd_nxt;
    out_stat_r <= out_stat_nxt;
    out_rd_r   <= out_rd_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("entry count above store depth");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_pend_r && rem_r != '0) |-> (wr_addr_r != step_a))
    else $error("shift writes the word it is reading");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == rdq_pkg::STAT_FULL) |-> (out_cnt_r == DEPTH_CNT))
    else $error("full status with store not full");

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECIDE))
    else $error("accepted request not decoded");

endmodule
